// ===== hdl/tphc_pkg.sv =====
// Shared types, codes and constants of the text printer head controller.
package tphc_pkg;

  // Tab stops fall on multiples of this column count (a power of two).
  localparam int unsigned TabStop    = 8;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [7:0] LineWidthReset = 8'd80;
  localparam logic [7:0] PageLinesReset = 8'd66;

  // Character codes.
  localparam logic [7:0] ChBel   = 8'h07;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChHt    = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChVt    = 8'h0b;
  localparam logic [7:0] ChFf    = 8'h0c;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSo    = 8'h0e;
  localparam logic [7:0] ChSi    = 8'h0f;
  localparam logic [7:0] ChDc1   = 8'h11;
  localparam logic [7:0] ChDc2   = 8'h12;
  localparam logic [7:0] ChDc3   = 8'h13;
  localparam logic [7:0] ChDc4   = 8'h14;
  localparam logic [7:0] ChCan   = 8'h18;
  localparam logic [7:0] ChEsc   = 8'h1b;
  localparam logic [7:0] ChSpace = 8'h20;

  // Control byte bits.
  localparam int unsigned CtrlStrobeBit   = 0;
  localparam int unsigned CtrlAutofeedBit = 1;
  localparam int unsigned CtrlInitBit     = 2;
  localparam logic [7:0]  ControlReset    = 8'h04;

  // Status byte: low bits and busy-not always set, ack-not set when no ack pending.
  localparam logic [7:0] StatusLow   = 8'h1f;
  localparam logic [7:0] StatusBusyN = 8'h80;
  localparam logic [7:0] StatusAckN  = 8'h40;

  typedef enum logic [2:0] {
    REQ_DATA   = 3'd0,
    REQ_CTRL   = 3'd1,
    REQ_STATUS = 3'd2,
    REQ_ACKEND = 3'd3,
    REQ_IDLE   = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_CELL   = 2'd1,
    KIND_EJECT  = 2'd2,
    KIND_IRQ    = 2'd3
  } kind_e;

  typedef enum logic [0:0] {
    CFG_LINE_WIDTH = 1'b0,
    CFG_PAGE_LINES = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_CTRL   = 2'd0,
    OP_STATUS = 2'd1,
    OP_ACK    = 2'd2,
    OP_IDLE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    BC_PRINT  = 3'd0,
    BC_IGNORE = 3'd1,
    BC_BS     = 3'd2,
    BC_HT     = 3'd3,
    BC_VT     = 3'd4,
    BC_FF     = 3'd5,
    BC_CR     = 3'd6,
    BC_LF     = 3'd7
  } byte_class_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_TAB   = 2'd1,
    BK_EJECT = 2'd2
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic        autofeed;
    logic        home;
    logic        strobe;
    byte_class_e byte_class;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] row;
    logic [7:0] column;
    logic [7:0] cell_char;
    logic [7:0] line_count;
    logic [7:0] status_byte;
    logic       last;
  } result_t;

endpackage

// ===== hdl/tphc_front.sv =====
// Front end: takes requests, tracks the data latch and control edges, issues commands.
module tphc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // value
  input  logic [2:0]          s_axis_tuser,  // req_type
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output tphc_pkg::cmd_t      push_cmd_o
);

  logic [7:0] data_latch_q, data_latch_d;
  logic [7:0] control_last_q, control_last_d;
  logic       accept;
  tphc_pkg::byte_class_e byte_class;

  assign s_axis_tready = push_ready_i;
  assign accept        = s_axis_tvalid && push_ready_i;

  always_comb begin
    case (data_latch_q) inside
      tphc_pkg::ChBel, tphc_pkg::ChSo, tphc_pkg::ChSi, tphc_pkg::ChDc1, tphc_pkg::ChDc2,
      tphc_pkg::ChDc3, tphc_pkg::ChDc4, tphc_pkg::ChCan, tphc_pkg::ChEsc:
        byte_class = tphc_pkg::BC_IGNORE;
      tphc_pkg::ChBs: byte_class = tphc_pkg::BC_BS;
      tphc_pkg::ChHt: byte_class = tphc_pkg::BC_HT;
      tphc_pkg::ChVt: byte_class = tphc_pkg::BC_VT;
      tphc_pkg::ChFf: byte_class = tphc_pkg::BC_FF;
      tphc_pkg::ChCr: byte_class = tphc_pkg::BC_CR;
      tphc_pkg::ChLf: byte_class = tphc_pkg::BC_LF;
      default:        byte_class = tphc_pkg::BC_PRINT;
    endcase
  end

  always_comb begin
    data_latch_d   = data_latch_q;
    control_last_d = control_last_q;
    push_valid_o   = 1'b0;
    push_cmd_o.op         = tphc_pkg::OP_CTRL;
    push_cmd_o.autofeed   = s_axis_tdata[tphc_pkg::CtrlAutofeedBit];
    push_cmd_o.home       = s_axis_tdata[tphc_pkg::CtrlInitBit] &&
                            !control_last_q[tphc_pkg::CtrlInitBit];
    push_cmd_o.strobe     = !s_axis_tdata[tphc_pkg::CtrlStrobeBit] &&
                            control_last_q[tphc_pkg::CtrlStrobeBit];
    push_cmd_o.byte_class = byte_class;
    push_cmd_o.data       = data_latch_q;
    case (tphc_pkg::req_e'(s_axis_tuser))
      tphc_pkg::REQ_DATA: begin
        if (accept) data_latch_d = s_axis_tdata;
      end
      tphc_pkg::REQ_CTRL: begin
        push_valid_o = s_axis_tvalid;
        if (accept) control_last_d = s_axis_tdata;
      end
      tphc_pkg::REQ_STATUS: begin
        push_valid_o  = s_axis_tvalid;
        push_cmd_o.op = tphc_pkg::OP_STATUS;
      end
      tphc_pkg::REQ_ACKEND: begin
        push_valid_o  = s_axis_tvalid;
        push_cmd_o.op = tphc_pkg::OP_ACK;
      end
      tphc_pkg::REQ_IDLE: begin
        push_valid_o  = s_axis_tvalid;
        push_cmd_o.op = tphc_pkg::OP_IDLE;
      end
      default: ;  // unused request codes: drop
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_latch_q   <= '0;
      control_last_q <= tphc_pkg::ControlReset;
    end else begin
      data_latch_q   <= data_latch_d;
      control_last_q <= control_last_d;
    end
  end

endmodule

// ===== hdl/tphc_queue.sv =====
// Short command queue between the front end and the print engine.
module tphc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  tphc_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output tphc_pkg::cmd_t pop_cmd_o
);

  tphc_pkg::cmd_t mem_q [tphc_pkg::QueueDepth];
  logic [tphc_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [tphc_pkg::QueuePtrW:0]   count_q;
  logic push, pop;

  assign push_ready_o = count_q != (tphc_pkg::QueuePtrW+1)'(tphc_pkg::QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

endmodule

// ===== hdl/tphc_back.sv =====
// Print engine: head position, page state, config registers and the result register.
module tphc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  tphc_pkg::cmd_t    cmd_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output tphc_pkg::result_t res_o
);

  tphc_pkg::back_state_e state_q, state_d;
  logic [7:0] col_q, col_d, row_q, row_d;
  logic       dirty_q, dirty_d, ack_q, ack_d;
  logic [7:0] tab_col_q, tab_col_d, lc_q, lc_d;
  logic [7:0] line_width_q, page_lines_q;
  logic       out_valid_q;
  tphc_pkg::result_t out_q, res_d;
  logic       emit, slot_free;

  // Head position after an optional home from the current control write.
  logic [7:0] col_h, row_h;
  logic       dirty_h;
  // Tab and line-feed step shared by the first cycle and the tab state.
  logic [7:0] step_col, step_row;
  logic       step_dirty;
  logic [8:0] step_next, lf_row;
  logic       tab_more, wrap, page_end;
  logic [7:0] lf_count;

  assign slot_free   = !out_valid_q || res_ready_i;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    col_h   = cmd_i.home ? 8'd0 : col_q;
    row_h   = cmd_i.home ? 8'd0 : row_q;
    dirty_h = cmd_i.home ? 1'b0 : dirty_q;

    step_col   = (state_q == tphc_pkg::BK_TAB) ? tab_col_q : col_h;
    step_row   = (state_q == tphc_pkg::BK_TAB) ? row_q     : row_h;
    step_dirty = (state_q == tphc_pkg::BK_TAB) ? dirty_q   : dirty_h;
    step_next  = {1'b0, step_col} + 9'd1;
    wrap       = step_next >= {1'b0, line_width_q};
    tab_more   = !wrap && (step_next % tphc_pkg::TabStop) != '0;
    lf_row     = {1'b0, step_row} + 9'd1;
    page_end   = lf_row >= {1'b0, page_lines_q};
    lf_count   = lf_row[8] ? 8'hff : lf_row[7:0];
  end

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    dirty_d   = dirty_q;
    ack_d     = ack_q;
    tab_col_d = tab_col_q;
    lc_d      = lc_q;
    emit      = 1'b0;
    res_d     = '0;
    res_d.last = 1'b1;
    cmd_ready_o = 1'b0;

    case (state_q)
      tphc_pkg::BK_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          cmd_ready_o = 1'b1;
          case (cmd_i.op)
            tphc_pkg::OP_STATUS: begin
              emit = 1'b1;
              res_d.kind = tphc_pkg::KIND_STATUS;
              res_d.status_byte = tphc_pkg::StatusLow | tphc_pkg::StatusBusyN |
                                  (ack_q ? 8'h00 : tphc_pkg::StatusAckN);
            end
            tphc_pkg::OP_ACK: begin
              if (ack_q) begin
                ack_d = 1'b0;
                emit  = 1'b1;
                res_d.kind = tphc_pkg::KIND_IRQ;
              end
            end
            tphc_pkg::OP_IDLE: begin
              if (dirty_q) begin
                emit = 1'b1;
                res_d.kind = tphc_pkg::KIND_EJECT;
                res_d.line_count = row_q;
                row_d   = '0;
                dirty_d = 1'b0;
              end
            end
            default: begin  // control write
              col_d   = col_h;
              row_d   = row_h;
              dirty_d = dirty_h;
              ack_d   = cmd_i.home ? 1'b0 : ack_q;
              if (cmd_i.strobe) begin
                ack_d = 1'b1;
                case (cmd_i.byte_class)
                  tphc_pkg::BC_IGNORE: ;
                  tphc_pkg::BC_BS: begin
                    if (col_h != '0) col_d = col_h - 8'd1;
                  end
                  tphc_pkg::BC_VT: col_d = '0;
                  tphc_pkg::BC_FF: begin
                    if (dirty_h) begin
                      emit = 1'b1;
                      res_d.kind = tphc_pkg::KIND_EJECT;
                      res_d.line_count = row_h;
                    end
                    row_d   = '0;
                    dirty_d = 1'b0;
                  end
                  tphc_pkg::BC_CR, tphc_pkg::BC_LF: begin
                    col_d = '0;
                    if (cmd_i.byte_class == tphc_pkg::BC_LF || cmd_i.autofeed) begin
                      if (page_end) begin
                        if (dirty_h) begin
                          emit = 1'b1;
                          res_d.kind = tphc_pkg::KIND_EJECT;
                          res_d.line_count = lf_count;
                        end
                        row_d   = '0;
                        dirty_d = 1'b0;
                      end else begin
                        row_d = lf_row[7:0];
                      end
                    end
                  end
                  tphc_pkg::BC_HT: begin
                    emit = 1'b1;
                    res_d.kind      = tphc_pkg::KIND_CELL;
                    res_d.row       = row_h;
                    res_d.column    = col_h;
                    res_d.cell_char = tphc_pkg::ChSpace;
                    if (tab_more) begin
                      res_d.last = 1'b0;
                      tab_col_d  = step_next[7:0];
                      state_d    = tphc_pkg::BK_TAB;
                    end else if (wrap) begin
                      col_d = '0;
                      if (page_end) begin
                        if (dirty_h) begin
                          res_d.last = 1'b0;
                          lc_d       = lf_count;
                          state_d    = tphc_pkg::BK_EJECT;
                        end else begin
                          row_d = '0;
                        end
                      end else begin
                        row_d = lf_row[7:0];
                      end
                    end else begin
                      col_d = step_next[7:0];
                    end
                  end
                  default: begin  // printable
                    emit = 1'b1;
                    res_d.kind      = tphc_pkg::KIND_CELL;
                    res_d.row       = row_h;
                    res_d.column    = col_h;
                    res_d.cell_char = cmd_i.data;
                    dirty_d = 1'b1;
                    if (wrap) begin
                      col_d = '0;
                      if (page_end) begin
                        res_d.last = 1'b0;
                        lc_d       = lf_count;
                        state_d    = tphc_pkg::BK_EJECT;
                      end else begin
                        row_d = lf_row[7:0];
                      end
                    end else begin
                      col_d = step_next[7:0];
                    end
                  end
                endcase
              end
            end
          endcase
        end
      end
      tphc_pkg::BK_TAB: begin
        if (slot_free) begin
          emit = 1'b1;
          res_d.kind      = tphc_pkg::KIND_CELL;
          res_d.row       = row_q;
          res_d.column    = tab_col_q;
          res_d.cell_char = tphc_pkg::ChSpace;
          state_d = tphc_pkg::BK_IDLE;
          if (tab_more) begin
            res_d.last = 1'b0;
            tab_col_d  = step_next[7:0];
            state_d    = tphc_pkg::BK_TAB;
          end else if (wrap) begin
            col_d = '0;
            if (page_end) begin
              if (step_dirty) begin
                res_d.last = 1'b0;
                lc_d       = lf_count;
                state_d    = tphc_pkg::BK_EJECT;
              end else begin
                row_d = '0;
              end
            end else begin
              row_d = lf_row[7:0];
            end
          end else begin
            col_d = step_next[7:0];
          end
        end
      end
      tphc_pkg::BK_EJECT: begin
        if (slot_free) begin
          emit = 1'b1;
          res_d.kind       = tphc_pkg::KIND_EJECT;
          res_d.line_count = lc_q;
          row_d   = '0;
          dirty_d = 1'b0;
          state_d = tphc_pkg::BK_IDLE;
        end
      end
      default: state_d = tphc_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tphc_pkg::BK_IDLE;
      col_q        <= '0;
      row_q        <= '0;
      dirty_q      <= 1'b0;
      ack_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      line_width_q <= tphc_pkg::LineWidthReset;
      page_lines_q <= tphc_pkg::PageLinesReset;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      dirty_q <= dirty_d;
      ack_q   <= ack_d;
      if (emit)             out_valid_q <= 1'b1;
      else if (res_ready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        case (tphc_pkg::cfg_idx_e'(cfg_index_i))
          tphc_pkg::CFG_LINE_WIDTH: line_width_q <= cfg_data_i;
          tphc_pkg::CFG_PAGE_LINES: page_lines_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers: loaded only when a result is issued.
  always_ff @(posedge clk_i) begin
    tab_col_q <= tab_col_d;
    lc_q      <= lc_d;
    if (emit) out_q <= res_d;
  end

endmodule

// ===== hdl/text_printer_head_controller_unit.sv =====
// Top level of the text printer head controller.
//
//  Channel   Direction  Contents
//  s_axis    in         tdata: value; tuser: req_type
//  m_axis    out        tdata: row, column, cell_char, line_count, status_byte;
//                       tuser: kind; tlast: last
//  cfg       in         cfg_index_i selects line_width (0) or page_lines (1)
//
// The front end takes one request per cycle while the four-entry command queue has room.
// The print engine spends one cycle per result while m_axis is ready; a tab emits up to
// 8 cells plus a page eject, and the next command waits until its last result is issued.
// A stalled m_axis holds the engine; the queue keeps the front end taking requests.
// Reset (rst_ni low) homes the head, clears the page and restores 80 columns, 66 lines.
module text_printer_head_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] value
  input  logic [2:0]  s_axis_tuser,  // [2:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // row, column, cell_char, line_count, status_byte
  output logic [1:0]  m_axis_tuser,  // [1:0] kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic              push_valid, push_ready, pop_valid, pop_ready;
  tphc_pkg::cmd_t    push_cmd, pop_cmd;
  tphc_pkg::result_t res;

  assign cfg_ready_o = 1'b1;

  tphc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_cmd_o    (push_cmd)
  );

  tphc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  tphc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {res.status_byte, res.line_count, res.cell_char, res.column, res.row};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// ===== hdl/tphc_checker.sv =====
// Port-level checks on the text printer head controller, bound to the top level.
module tphc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // Hold a result that is not yet transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == tphc_pkg::KIND_STATUS |->
      m_axis_tdata[39:32] == 8'hdf || m_axis_tdata[39:32] == 8'h9f)
    else $error("bad status byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != tphc_pkg::KIND_CELL |-> m_axis_tdata[23:0] == '0)
    else $error("cell fields set on a non-cell result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tphc_pkg::KIND_STATUS ||
                      m_axis_tuser == tphc_pkg::KIND_IRQ ||
                      m_axis_tuser == tphc_pkg::KIND_EJECT) |-> m_axis_tlast)
    else $error("status, interrupt or eject not the final result");

endmodule

bind text_printer_head_controller_unit tphc_checker u_tphc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
